// File: src/flt_pkg.sv
// shared types and codes for the fingerprint leaf table
package flt_pkg;

	localparam int KEY_W = 64;
	localparam int VAL_W = 64;
	localparam int TAG_W = 8;
	localparam int IDX_OUT_W = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_FOUND     = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic             lookup;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} queue_head_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EXEC,
		BK_SCAN,
		BK_CHECK
	} back_state_t;

endpackage

// File: src/flt_ram.sv
// generic single write port ram with registered read
module flt_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/flt_front.sv
// request intake, decode and two-entry command queue
module flt_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                operation,
	input  logic [63:0]         search_key,
	input  logic [63:0]         entry_value,
	output logic                busy,
	input  logic                pop,
	output flt_pkg::queue_head_t head
);
	import flt_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       do_pop;
	cmd_t       incoming;

	assign busy = (count_q == 2'd2);
	assign push = start & ~busy;
	assign do_pop = pop & (count_q != 2'd0);

	// classify the request
	always_comb begin
		incoming.lookup = (operation == OP_LOOKUP);
		incoming.key = search_key;
		incoming.value = entry_value;
	end

	assign head.valid = (count_q != 2'd0);
	assign head.cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/flt_back.sv
// leaf execution: slot allocation, fingerprint filter and key check
module flt_back #(
	parameter int SLOTS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  flt_pkg::queue_head_t  head,
	output logic                  pop,
	output logic                  done,
	output logic [1:0]            status,
	output logic [63:0]           found_value,
	output logic [4:0]            slot_index
);
	import flt_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	back_state_t            state_q, state_n;
	cmd_t                   cmd_q;
	logic [SLOTS-1:0]       valid_q, valid_n;
	logic [TAG_W-1:0]       tag_q [SLOTS];
	logic [SLOTS-1:0]       cand_q, cand_n;
	logic [IDX_W-1:0]       cur_q, cur_n;

	logic                   done_n;
	logic [1:0]             status_n;
	logic [VAL_W-1:0]       value_n;
	logic [IDX_OUT_W-1:0]   index_n;
	logic                   done_q;
	logic [1:0]             status_q;
	logic [VAL_W-1:0]       value_q;
	logic [IDX_OUT_W-1:0]   index_q;

	logic [SLOTS-1:0]       free_vec;
	logic [SLOTS-1:0]       tag_hit;
	logic [IDX_W-1:0]       free_idx;
	logic [IDX_W-1:0]       cand_idx;
	logic                   tag_we;

	logic                   ram_we;
	logic [KEY_W+VAL_W-1:0] ram_rdata;
	logic [KEY_W-1:0]       rd_key;
	logic [VAL_W-1:0]       rd_val;

	assign free_vec = ~valid_q;
	assign rd_key = ram_rdata[KEY_W+VAL_W-1:VAL_W];
	assign rd_val = ram_rdata[VAL_W-1:0];

	// fingerprint filter across all slots
	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			tag_hit[i] = valid_q[i] & (tag_q[i] == cmd_q.key[TAG_W-1:0]);
		end
	end

	// lowest free slot and lowest remaining candidate
	always_comb begin
		free_idx = '0;
		cand_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				free_idx = IDX_W'(i);
			end
			if (cand_q[i]) begin
				cand_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		state_n = state_q;
		valid_n = valid_q;
		cand_n = cand_q;
		cur_n = cur_q;
		pop = 1'b0;
		ram_we = 1'b0;
		tag_we = 1'b0;
		done_n = 1'b0;
		status_n = status_q;
		value_n = value_q;
		index_n = index_q;
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					state_n = BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (!cmd_q.lookup) begin
					done_n = 1'b1;
					value_n = '0;
					if (|free_vec) begin
						ram_we = 1'b1;
						tag_we = 1'b1;
						valid_n[free_idx] = 1'b1;
						status_n = ST_INSERTED;
						index_n = IDX_OUT_W'(free_idx);
					end else begin
						status_n = ST_FULL;
						index_n = '0;
					end
					state_n = BK_IDLE;
				end else begin
					cand_n = tag_hit;
					state_n = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (cand_q == '0) begin
					done_n = 1'b1;
					status_n = ST_NOT_FOUND;
					value_n = '0;
					index_n = '0;
					state_n = BK_IDLE;
				end else begin
					cur_n = cand_idx;
					state_n = BK_CHECK;
				end
			end
			BK_CHECK: begin
				if (rd_key == cmd_q.key) begin
					done_n = 1'b1;
					status_n = ST_FOUND;
					value_n = rd_val;
					index_n = IDX_OUT_W'(cur_q);
					state_n = BK_IDLE;
				end else begin
					cand_n[cur_q] = 1'b0;
					state_n = BK_SCAN;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	flt_ram #(
		.WIDTH(KEY_W + VAL_W),
		.DEPTH(SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(free_idx),
		.wdata({cmd_q.key, cmd_q.value}),
		.raddr(cand_idx),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head.cmd;
		end
		if (tag_we) begin
			tag_q[free_idx] <= cmd_q.key[TAG_W-1:0];
		end
		cand_q <= cand_n;
		cur_q <= cur_n;
		status_q <= status_n;
		value_q <= value_n;
		index_q <= index_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_n;
			valid_q <= valid_n;
			done_q <= done_n;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign found_value = value_q;
	assign slot_index = index_q;

endmodule

// File: src/fingerprint_leaf_table_unit.sv
// top level of the fingerprint leaf table
// insert: the idle sequencer pops a command, writes the lowest free slot and registers the result strobe
// lookup: fingerprint hits become candidates; SCAN and CHECK alternate, reading the lowest candidate's key
//   from the slot ram per pass; a new command is popped only once the sequencer is back in idle
// two-entry queue between intake and execution, busy only when full; done strobes, no stall
// reset clears the valid bitmap, queue and sequencer; slot contents stay undefined
module fingerprint_leaf_table_unit #(
	parameter int SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [63:0] search_key,
	input  logic [63:0] entry_value,
	output logic        done,
	output logic [1:0]  status,
	output logic [63:0] found_value,
	output logic [4:0]  slot_index
);
	import flt_pkg::*;

	// head of the request queue and the pop back from execution
	queue_head_t head;
	logic        pop;

	// front: takes a request whenever the queue has room, decodes the operation
	flt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.operation  (operation),
		.search_key (search_key),
		.entry_value(entry_value),
		.busy       (busy),
		.pop        (pop),
		.head       (head)
	);

	// back: allocates on insert, filters by fingerprint then checks keys on lookup
	flt_back #(
		.SLOTS(SLOTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.status     (status),
		.found_value(found_value),
		.slot_index (slot_index)
	);

endmodule

// File: dv/tb_fingerprint_leaf_table_unit.sv
// self-checking testbench for the fingerprint leaf table unit
module tb_fingerprint_leaf_table_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import flt_pkg::*;

	localparam int LEAF_SLOTS = 32;
	// worst lookup checks all 32 slots, leave room for a stray strobe after the drain
	localparam int SETTLE_CYCLES = 100;
	localparam int RANDOM_REQUESTS = 1700;

	// one result as the unit reports it
	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] value;
		logic [4:0]  index;
	} leaf_result_t;

	// one line of the directed plan; count > 1 sends a run of requests
	// with the key stepped by step and the data stepped by one
	typedef struct packed {
		logic         op;
		logic [63:0]  key;
		logic [63:0]  data;
		logic [63:0]  step;
		logic [5:0]   count;
		logic         typed;
		leaf_result_t want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        operation = OP_INSERT;
	logic [63:0] search_key = '0;
	logic [63:0] entry_value = '0;
	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [63:0] found_value;
	logic [4:0]  slot_index;

	// shadow copy of the leaf contents
	logic [LEAF_SLOTS-1:0] shadow_valid = '0;
	logic [63:0]           shadow_key [LEAF_SLOTS];
	logic [63:0]           shadow_data [LEAF_SLOTS];
	logic [7:0]            shadow_tag [LEAF_SLOTS];

	leaf_result_t pending_results[$];
	plan_row_t    leaf_plan[$];
	int           mismatches = 0;

	always #2 clk = ~clk;

	fingerprint_leaf_table_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.search_key  (search_key),
		.entry_value (entry_value),
		.done        (done),
		.status      (status),
		.found_value (found_value),
		.slot_index  (slot_index)
	);

	// insert takes the lowest free slot, lookup the lowest valid slot whose
	// fingerprint and key both match; a full leaf refuses and keeps its state
	function automatic leaf_result_t predict_leaf(input logic op, input logic [63:0] key,
			input logic [63:0] data);
		leaf_result_t r;
		r = '0;
		if (op == OP_INSERT) begin
			r.status = ST_FULL;
			for (int i = 0; i < LEAF_SLOTS; i++) begin
				if (!shadow_valid[i]) begin
					shadow_key[i] = key;
					shadow_data[i] = data;
					shadow_tag[i] = key[7:0];
					shadow_valid[i] = 1'b1;
					r.status = ST_INSERTED;
					r.index = i[4:0];
					return r;
				end
			end
			return r;
		end
		r.status = ST_NOT_FOUND;
		for (int i = 0; i < LEAF_SLOTS; i++) begin
			if (shadow_valid[i] && shadow_tag[i] == key[7:0] && shadow_key[i] == key) begin
				r.status = ST_FOUND;
				r.value = shadow_data[i];
				r.index = i[4:0];
				return r;
			end
		end
		return r;
	endfunction

	function automatic void add_row(input logic op, input logic [63:0] key,
			input logic [63:0] data, input logic [63:0] step, input int count,
			input logic typed, input leaf_result_t want);
		plan_row_t row;
		row.op = op;
		row.key = key;
		row.data = data;
		row.step = step;
		row.count = count[5:0];
		row.typed = typed;
		row.want = want;
		leaf_plan.push_back(row);
	endfunction

	// drive one request and hold it until the unit takes it; the shadow
	// leaf moves on the edge that accepts the request
	task automatic issue_request(input logic op, input logic [63:0] key,
			input logic [63:0] data, input logic typed, input leaf_result_t want);
		leaf_result_t predicted;
		start <= 1'b1;
		operation <= op;
		search_key <= key;
		entry_value <= data;
		do @(posedge clk); while (busy);
		predicted = predict_leaf(op, key, data);
		pending_results.push_back(typed ? want : predicted);
	endtask

	// sender gaps, about 14 in a hundred requests, none inside the quiet stretch
	task automatic maybe_gap(input bit quiet);
		if (!quiet && $urandom_range(99, 0) < 14) begin
			start <= 1'b0;
			repeat ($urandom_range(5, 1)) @(posedge clk);
		end
	endtask

	// hold off until every request in flight has reported
	task automatic drain_leaf();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// result checker: every strobe must match the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d value %h index %0d",
					status, found_value, slot_index);
				mismatches++;
			end else begin
				leaf_result_t want;
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, status);
					mismatches++;
				end
				if (found_value !== want.value) begin
					$error("found_value: expected %h actual %h", want.value, found_value);
					mismatches++;
				end
				if (slot_index !== want.index) begin
					$error("slot_index: expected %0d actual %0d", want.index, slot_index);
					mismatches++;
				end
			end
		end
	end

	// hard stop well past the slowest legal run
	initial begin
		#2_000_000;
		$display("fingerprint_leaf_table_unit: mismatch");
		$finish;
	end

	initial begin
		logic [63:0]  key;
		logic [63:0]  data;
		logic         op;
		int           slot;
		int           pick;
		plan_row_t    row;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty leaf: lookups at the key extremes miss
		add_row(OP_LOOKUP, 64'd0, '1, '0, 1, 1'b1, {ST_NOT_FOUND, 64'd0, 5'd0});
		add_row(OP_LOOKUP, '1, 64'd0, '0, 1, 1'b1, {ST_NOT_FOUND, 64'd0, 5'd0});
		// key and data extremes into the first two slots
		add_row(OP_INSERT, 64'd0, '1, '0, 1, 1'b1, {ST_INSERTED, 64'd0, 5'd0});
		add_row(OP_INSERT, '1, 64'd0, '0, 1, 1'b1, {ST_INSERTED, 64'd0, 5'd1});
		add_row(OP_LOOKUP, 64'd0, 64'd0, '0, 1, 1'b1, {ST_FOUND, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0});
		add_row(OP_LOOKUP, '1, '1, '0, 1, 1'b1, {ST_FOUND, 64'd0, 5'd1});
		// same fingerprint as key zero, different key
		add_row(OP_INSERT, 64'h100, 64'h1234, '0, 1, 1'b1, {ST_INSERTED, 64'd0, 5'd2});
		add_row(OP_LOOKUP, 64'h200, 64'd0, '0, 1, 1'b1, {ST_NOT_FOUND, 64'd0, 5'd0});
		add_row(OP_LOOKUP, 64'h100, 64'd0, '0, 1, 1'b1, {ST_FOUND, 64'h1234, 5'd2});
		// duplicate key goes in, lookup still returns the lowest copy
		add_row(OP_INSERT, 64'd0, 64'd5, '0, 1, 1'b1, {ST_INSERTED, 64'd0, 5'd3});
		add_row(OP_LOOKUP, 64'd0, 64'd0, '0, 1, 1'b1, {ST_FOUND, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0});
		add_row(OP_LOOKUP, 64'h8000_0000_0000_0000, 64'd0, '0, 1, 1'b1,
			{ST_NOT_FOUND, 64'd0, 5'd0});
		// fill the rest; four fingerprints shared seven ways each, so later
		// lookups walk long chains of fingerprint hits with wrong keys
		add_row(OP_INSERT, 64'h5A00_0000_0000_0000, 64'hC0DE_0000_0000_0000,
			64'h0000_0001_0000_0040, 28, 1'b0, '0);
		// leaf full: refused and flagged, nothing written
		add_row(OP_INSERT, 64'd7, 64'd7, '0, 1, 1'b1, {ST_FULL, 64'd0, 5'd0});
		add_row(OP_INSERT, '1, '1, '0, 1, 1'b1, {ST_FULL, 64'd0, 5'd0});
		add_row(OP_LOOKUP, 64'h5A00_001B_0000_06C0, 64'd0, '0, 1, 1'b1,
			{ST_FOUND, 64'hC0DE_0000_0000_001B, 5'd31});
		add_row(OP_LOOKUP, 64'h5A00_0000_0000_0000, 64'd0, '0, 1, 1'b0, '0);
		add_row(OP_LOOKUP, 64'd7, 64'd0, '0, 1, 1'b1, {ST_NOT_FOUND, 64'd0, 5'd0});

		foreach (leaf_plan[r]) begin
			row = leaf_plan[r];
			for (int i = 0; i < row.count; i++) begin
				maybe_gap(1'b0);
				issue_request(row.op, row.key + row.step * i, row.data + i,
					row.typed && row.count == 1, row.want);
			end
		end
		drain_leaf();

		// random part on the full leaf: mostly lookups built from stored keys,
		// some near misses, some noise, and refused inserts
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			slot = $urandom_range(LEAF_SLOTS - 1, 0);
			pick = $urandom_range(99, 0);
			data = {$urandom, $urandom};
			op = OP_LOOKUP;
			if (pick < 10) begin
				op = OP_INSERT;
				key = {$urandom, $urandom};
			end else if (pick < 40) begin
				key = shadow_key[slot];
			end else if (pick < 65) begin
				// fingerprint hit, key almost surely wrong: slow path
				key = {$urandom, $urandom};
				key[7:0] = shadow_key[slot][7:0];
			end else if (pick < 80) begin
				key = shadow_key[slot] ^ (64'd1 << $urandom_range(63, 0));
			end else begin
				key = {$urandom, $urandom};
			end
			if (n == 400)
				drain_leaf();
			else
				maybe_gap(n >= 700 && n < 1100);
			issue_request(op, key, data, 1'b0, '0);
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("fingerprint_leaf_table_unit: match");
		else
			$display("fingerprint_leaf_table_unit: mismatch");
		$finish;
	end

endmodule

// File: files.f
src/flt_pkg.sv
src/flt_ram.sv
src/flt_front.sv
src/flt_back.sv
src/fingerprint_leaf_table_unit.sv
dv/tb_fingerprint_leaf_table_unit.sv
